// File: hdl/clh_pkg.sv
// ----------------------------------------------------------------------------
// clh_pkg
// Shared constants, codes and types of the command latency histogram core.
// ----------------------------------------------------------------------------
package clh_pkg;

	// sizing
	localparam int NUM_COMMANDS = 256;
	localparam int MAX_BOUNDS   = 7;
	localparam int NUM_BUCKETS  = MAX_BOUNDS + 1;
	localparam int CMD_AW       = $clog2(NUM_COMMANDS);

	// field widths
	localparam int CNT_W      = 64;
	localparam int LAT_W      = 32;
	localparam int ID_W       = 8;
	localparam int CODE_W     = 2;
	localparam int BSEL_W     = 3;
	localparam int NBND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// memory rows: four per-command counters, and one row of bucket counters
	localparam int STATS_W = 4 * CNT_W;
	localparam int BKT_W   = NUM_BUCKETS * CNT_W;

	// event codes; the spare code behaves as a read
	localparam logic [CODE_W-1:0] CMD_CALL = 2'd0;
	localparam logic [CODE_W-1:0] CMD_LAT  = 2'd1;
	localparam logic [CODE_W-1:0] CMD_READ = 2'd2;

	// register indexes; bounds follow the first one
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_IN_USE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_0       = 3'd1;

	// controller to datapath
	typedef struct packed {
		logic load;    // input transaction taken, read rows
		logic commit;  // write back and load the result register
	} clh_ctl_t;

endpackage

// File: hdl/command_latency_histogram_core.sv
// ----------------------------------------------------------------------------
// command_latency_histogram_core
// Per-command call/latency statistics engine with a bucketed latency histogram.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_ready    | command, cmd_id, latency, bucket_sel
//  result   | out_valid / out_ready  | total_count .. hist_latency_total,
//           |                        | bucket_num, bucket_count
//  config   | cfg_we (no wait)       | cfg_index, cfg_data
//
//  The accept cycle reads the command's rows and picks the bucket; the commit,
//  in the update state, writes back and loads the result register.
//  The result register decouples the sides; a new transaction is taken while
//  a result waits, and only the commit stalls while that result is not taken.
//  Reset: no clearing pass; a per-command valid bit makes unwritten rows zero.
//
// ----------------------------------------------------------------------------
module command_latency_histogram_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [clh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [clh_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input transactions
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [clh_pkg::CODE_W-1:0]        command,
	input  logic [clh_pkg::ID_W-1:0]          cmd_id,
	input  logic [clh_pkg::LAT_W-1:0]         latency,
	input  logic [clh_pkg::BSEL_W-1:0]        bucket_sel,
	// result transactions
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [clh_pkg::CNT_W-1:0]         total_count,
	output logic [clh_pkg::CNT_W-1:0]         cmd_call_count,
	output logic [clh_pkg::CNT_W-1:0]         cmd_latency_total,
	output logic [clh_pkg::CNT_W-1:0]         hist_call_count,
	output logic [clh_pkg::CNT_W-1:0]         hist_latency_total,
	output logic [clh_pkg::BSEL_W-1:0]        bucket_num,
	output logic [clh_pkg::CNT_W-1:0]         bucket_count
);

	import clh_pkg::*;

	// load / commit strobes from the sequencer
	clh_ctl_t ctl;

	// sequencer: idle -> update -> idle; commit waits for a free result slot
	clh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// datapath: bounds, bucket pick, counter RAMs and result register
	clh_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.command            (command),
		.cmd_id             (cmd_id),
		.latency            (latency),
		.bucket_sel         (bucket_sel),
		.total_count        (total_count),
		.cmd_call_count     (cmd_call_count),
		.cmd_latency_total  (cmd_latency_total),
		.hist_call_count    (hist_call_count),
		.hist_latency_total (hist_latency_total),
		.bucket_num         (bucket_num),
		.bucket_count       (bucket_count)
	);

endmodule

// File: hdl/clh_ram.sv
// ----------------------------------------------------------------------------
// clh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/clh_ctrl.sv
// ----------------------------------------------------------------------------
// clh_ctrl
// Sequencer: takes one transaction, then commits it into the result register.
// ----------------------------------------------------------------------------
module clh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output clh_pkg::clh_ctl_t ctl
);

	import clh_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		ctl.load   = in_valid & in_ready;
		// hold in update until the result slot is free
		ctl.commit = (state_q == ST_UPDATE) & (~out_valid_q | out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.load) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (ctl.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("clh_ctrl: state not one-hot");

	a_load_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == ST_UPDATE))
		else $error("clh_ctrl: accepted transaction did not move to update");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> (out_valid_q && state_q == ST_IDLE))
		else $error("clh_ctrl: commit did not present a result");
`endif

endmodule

// File: hdl/clh_dp.sv
// ----------------------------------------------------------------------------
// clh_dp
// Datapath: configuration, bucket pick, counter memories and result register.
// ----------------------------------------------------------------------------
module clh_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  clh_pkg::clh_ctl_t                    ctl,
	input  logic                                 cfg_we,
	input  logic [clh_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [clh_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [clh_pkg::CODE_W-1:0]           command,
	input  logic [clh_pkg::ID_W-1:0]             cmd_id,
	input  logic [clh_pkg::LAT_W-1:0]            latency,
	input  logic [clh_pkg::BSEL_W-1:0]           bucket_sel,
	output logic [clh_pkg::CNT_W-1:0]            total_count,
	output logic [clh_pkg::CNT_W-1:0]            cmd_call_count,
	output logic [clh_pkg::CNT_W-1:0]            cmd_latency_total,
	output logic [clh_pkg::CNT_W-1:0]            hist_call_count,
	output logic [clh_pkg::CNT_W-1:0]            hist_latency_total,
	output logic [clh_pkg::BSEL_W-1:0]           bucket_num,
	output logic [clh_pkg::CNT_W-1:0]            bucket_count
);

	import clh_pkg::*;

	// configuration
	logic [NBND_W-1:0] bounds_in_use_q;
	logic [LAT_W-1:0]  bound_q [MAX_BOUNDS];

	// decode at accept
	logic [NBND_W-1:0] used;
	logic [BSEL_W-1:0] pick;
	logic              hist_en;
	logic              in_range;
	logic [BSEL_W-1:0] bidx_in;

	// first stage
	logic [CODE_W-1:0] cmd_s1;
	logic [CMD_AW-1:0] id_s1;
	logic [LAT_W-1:0]  lat_s1;
	logic [BSEL_W-1:0] bidx_s1;
	logic              hist_s1;
	logic              inr_s1;

	// memories and row valid bits
	logic [STATS_W-1:0]      stats_rd;
	logic [BKT_W-1:0]        bkt_rd;
	logic [NUM_COMMANDS-1:0] vld_q;
	logic                    wr;

	// update
	logic                                 is_call, is_lat, bkt_inc, bkt_hit;
	logic [STATS_W-1:0]                   stats_old, stats_new;
	logic [NUM_BUCKETS-1:0][CNT_W-1:0]    bkt_old, bkt_new;
	logic [CNT_W-1:0]                     calls_new, lsum_new, hcalls_new, hlsum_new;
	logic [CNT_W-1:0]                     bkt_cnt_new, glob_new;
	logic [CNT_W-1:0]                     glob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_in_use_q <= '0;
			for (int i = 0; i < MAX_BOUNDS; i++) bound_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_BOUNDS_IN_USE) begin
				bounds_in_use_q <= cfg_data[NBND_W-1:0];
			end
			for (int i = 0; i < MAX_BOUNDS; i++) begin
				if (cfg_index == REG_BOUND_0 + CFG_IDX_W'(i)) bound_q[i] <= cfg_data;
			end
		end
	end

	// bucket = count of used bounds strictly below the latency
	always_comb begin
		used = (bounds_in_use_q > NBND_W'(MAX_BOUNDS)) ? NBND_W'(MAX_BOUNDS)
			: bounds_in_use_q;
		hist_en = (used != '0);
		pick = '0;
		for (int i = 0; i < MAX_BOUNDS; i++) begin
			if ((NBND_W'(i) < used) && (bound_q[i] < latency)) pick = pick + BSEL_W'(1);
		end
		in_range = ({1'b0, cmd_id} < (ID_W+1)'(NUM_COMMANDS));
		bidx_in  = (command == CMD_LAT && hist_en) ? pick : bucket_sel;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_s1  <= command;
			id_s1   <= cmd_id[CMD_AW-1:0];
			lat_s1  <= latency;
			bidx_s1 <= in_range ? bidx_in : bucket_sel;
			hist_s1 <= hist_en;
			inr_s1  <= in_range;
		end
	end

	clh_ram #(.WIDTH(STATS_W), .DEPTH(NUM_COMMANDS)) u_stats_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (id_s1),
		.wdata (stats_new),
		.re    (ctl.load),
		.raddr (cmd_id[CMD_AW-1:0]),
		.rdata (stats_rd)
	);

	clh_ram #(.WIDTH(BKT_W), .DEPTH(NUM_COMMANDS)) u_bkt_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (id_s1),
		.wdata (bkt_new),
		.re    (ctl.load),
		.raddr (cmd_id[CMD_AW-1:0]),
		.rdata (bkt_rd)
	);

	// read-modify-write of one command's rows; never written rows read as zero
	always_comb begin
		is_call   = (cmd_s1 == CMD_CALL);
		is_lat    = (cmd_s1 == CMD_LAT);
		bkt_inc   = is_lat & hist_s1;
		bkt_hit   = ({1'b0, bidx_s1} < (BSEL_W+1)'(NUM_BUCKETS));
		stats_old = vld_q[id_s1] ? stats_rd : '0;
		bkt_old   = vld_q[id_s1] ? bkt_rd : '0;

		calls_new  = stats_old[0*CNT_W +: CNT_W] + CNT_W'(is_call);
		lsum_new   = stats_old[1*CNT_W +: CNT_W] + (is_lat ? CNT_W'(lat_s1) : '0);
		hcalls_new = stats_old[2*CNT_W +: CNT_W] + CNT_W'(is_call & hist_s1);
		hlsum_new  = stats_old[3*CNT_W +: CNT_W] + (bkt_inc ? CNT_W'(lat_s1) : '0);
		stats_new  = {hlsum_new, hcalls_new, lsum_new, calls_new};

		bkt_new     = bkt_old;
		bkt_cnt_new = '0;
		if (bkt_hit) begin
			bkt_cnt_new      = bkt_old[bidx_s1] + CNT_W'(bkt_inc);
			bkt_new[bidx_s1] = bkt_cnt_new;
		end

		glob_new = glob_q + CNT_W'(is_call & inr_s1);
		wr       = ctl.commit & inr_s1 & (is_call | is_lat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glob_q <= '0;
			vld_q  <= '0;
		end else if (ctl.commit) begin
			glob_q <= glob_new;
			if (wr) vld_q[id_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			total_count  <= glob_new;
			bucket_num   <= bidx_s1;
			if (inr_s1) begin
				cmd_call_count     <= calls_new;
				cmd_latency_total  <= lsum_new;
				hist_call_count    <= hcalls_new;
				hist_latency_total <= hlsum_new;
				bucket_count       <= bkt_cnt_new;
			end else begin
				cmd_call_count     <= '0;
				cmd_latency_total  <= '0;
				hist_call_count    <= '0;
				hist_latency_total <= '0;
				bucket_count       <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_call_bumps_total: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && inr_s1 && is_call) |=> (total_count == $past(glob_q) + 64'd1))
		else $error("clh_dp: call did not advance the global count");

	a_idle_total_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.commit |=> (glob_q == $past(glob_q)))
		else $error("clh_dp: global count moved without a commit");
`endif

endmodule
